/* src/harmonic_tone_generator_core_macros.svh */
// Assertion macros used by the harmonic tone generator checker.
`ifndef HARMONIC_TONE_GENERATOR_CORE_MACROS_SVH
`define HARMONIC_TONE_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HTG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("htg check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("htg check failed");

`endif

/* src/htg_pkg.sv */
// Shared constants, sine table and control types of the harmonic tone generator.
package htg_pkg;

  localparam int MAX_HARMONICS   = 8;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int PHASE_W  = 32;
  localparam int HCOUNT_W = 4;
  localparam int WEIGHT_W = 16;
  localparam int GAIN_W   = 20;
  localparam int LEN_W    = 16;
  localparam int CFG_DW   = 64;
  localparam int CFG_IW   = 3;
  localparam int OUT_W    = 16;

  localparam logic [CFG_IW-1:0] REG_PHASE_STEP     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_HARMONIC_COUNT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_WEIGHTS_LOW    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_WEIGHTS_HIGH   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_NORM_GAIN      = 3'd4;
  localparam logic [CFG_IW-1:0] REG_LOOP_LENGTH    = 3'd5;

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int TAB_AW  = SINE_TABLE_BITS - 1;
  localparam int KW      = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int PROD_W  = SAMPLE_BITS + WEIGHT_W + 1;
  localparam int ACC_W   = PROD_W + KW;
  localparam int SCALED_W = ACC_W + GAIN_W - 32;

  localparam longint unsigned AMP     = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // entry n sits in bits n*SAMPLE_BITS upward
  typedef logic [(QUARTER+1)*SAMPLE_BITS-1:0] sine_tab_t;

  // Quarter-wave sine, Taylor polynomial in Q2.30, rounded to the sample amplitude.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    tab = '0;
    for (int n = 0; n <= QUARTER; n++) begin
      x  = (HALF_PI_Q30 * longint'(n)) / QUARTER;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 156;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      if (s > ONE_Q30) s = ONE_Q30;
      tab[n*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'((s * AMP + (ONE_Q30 >> 1)) >> 30);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  typedef struct packed {
    logic          start;
    logic          step;
    logic [KW-1:0] step_k;
    logic          scale;
    logic          emit;
  } htg_cmd_t;

  typedef struct packed {
    logic [HCOUNT_W-1:0] count;
    logic                pipe_busy;
    logic                out_blocked;
  } htg_status_t;

endpackage

/* src/htg_ctrl.sv */
// Controller: sequences harmonic steps, drain, scaling and result load.
module htg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  htg_pkg::htg_status_t status_i,
  output htg_pkg::htg_cmd_t    cmd_o
);
  import htg_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HARM  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [KW-1:0] k_q, k_d;
  logic          last_k;

  assign last_k     = (HCOUNT_W'(k_q) + HCOUNT_W'(1)) == status_i.count;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    cmd_o        = '0;
    cmd_o.step_k = k_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          k_d         = '0;
          state_d     = ST_HARM;
        end
      end
      ST_HARM: begin
        cmd_o.step = 1'b1;
        if (last_k) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.out_blocked) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule

/* src/htg_datapath.sv */
// Datapath: config registers, phase state, sine lookup, MAC pipeline, scaling, output.
module htg_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [htg_pkg::CFG_IW-1:0]    cfg_index_i,
  input  logic [htg_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  logic                          restart_i,
  input  htg_pkg::htg_cmd_t             cmd_i,
  output htg_pkg::htg_status_t          status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [htg_pkg::OUT_W-1:0]     out_sample_o,
  output logic                          out_last_o
);
  import htg_pkg::*;

  // configuration
  logic [PHASE_W-1:0]  phase_step_q;
  logic [HCOUNT_W-1:0] hcount_q;
  logic [CFG_DW-1:0]   weights_low_q, weights_high_q;
  logic [GAIN_W-1:0]   gain_q;
  logic [LEN_W-1:0]    loop_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= '0;
      hcount_q       <= HCOUNT_W'(1);
      weights_low_q  <= '0;
      weights_high_q <= '0;
      gain_q         <= GAIN_W'(65536);
      loop_len_q     <= LEN_W'(13200);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PHASE_STEP:     phase_step_q   <= cfg_wdata_i[PHASE_W-1:0];
        REG_HARMONIC_COUNT: hcount_q       <= cfg_wdata_i[HCOUNT_W-1:0];
        REG_WEIGHTS_LOW:    weights_low_q  <= cfg_wdata_i;
        REG_WEIGHTS_HIGH:   weights_high_q <= cfg_wdata_i;
        REG_NORM_GAIN:      gain_q         <= cfg_wdata_i[GAIN_W-1:0];
        REG_LOOP_LENGTH:    loop_len_q     <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the harmonic count to 1..MAX_HARMONICS
  logic [HCOUNT_W-1:0] count_eff;

  always_comb begin
    if (hcount_q == '0) count_eff = HCOUNT_W'(1);
    else if (hcount_q > HCOUNT_W'(MAX_HARMONICS)) count_eff = HCOUNT_W'(MAX_HARMONICS);
    else count_eff = hcount_q;
  end

  // phase and position state
  logic [PHASE_W-1:0] base_q, cur_phase_q, hp_q;
  logic [LEN_W-1:0]   pos_q;
  logic [PHASE_W-1:0] base_cur;
  logic [LEN_W-1:0]   pos_cur, len_eff;
  logic               last_cur, last_q;

  assign base_cur = restart_i ? '0 : base_q;
  assign pos_cur  = restart_i ? '0 : pos_q;
  assign len_eff  = (loop_len_q == '0) ? LEN_W'(1) : loop_len_q;
  assign last_cur = ({1'b0, pos_cur} + (LEN_W+1)'(1)) >= {1'b0, len_eff};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      pos_q  <= '0;
    end else if (cmd_i.start) begin
      base_q <= last_cur ? '0 : base_cur + phase_step_q;
      pos_q  <= last_cur ? '0 : pos_cur + LEN_W'(1);
    end
  end

  // harmonic k phase runs as a sum of k copies of this item's base phase
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_phase_q <= base_cur;
      hp_q        <= base_cur;
      last_q      <= last_cur;
    end else if (cmd_i.step) begin
      hp_q <= hp_q + cur_phase_q;
    end
  end

  // sine lookup
  logic [SINE_TABLE_BITS-1:0]   idx;
  logic [1:0]                   quad;
  logic [SINE_TABLE_BITS-3:0]   pos_in_q;
  logic [TAB_AW-1:0]            tab_addr;
  logic [SAMPLE_BITS-1:0]       tab_mag;
  logic signed [SAMPLE_BITS-1:0] tab_val;
  logic [2*CFG_DW-1:0]          weights_all;

  assign idx      = hp_q[PHASE_W-1 -: SINE_TABLE_BITS];
  assign quad     = idx[SINE_TABLE_BITS-1 -: 2];
  assign pos_in_q = idx[SINE_TABLE_BITS-3:0];
  assign tab_addr = quad[0] ? TAB_AW'(QUARTER) - {1'b0, pos_in_q} : {1'b0, pos_in_q};
  assign tab_mag  = SINE_TAB[tab_addr * SAMPLE_BITS +: SAMPLE_BITS];
  assign tab_val  = quad[1] ? -$signed(tab_mag) : $signed(tab_mag);
  assign weights_all = {weights_high_q, weights_low_q};

  // MAC pipeline: lookup, multiply, accumulate
  logic signed [SAMPLE_BITS-1:0] tab_q;
  logic [WEIGHT_W-1:0]           w_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic                          v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.step;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      tab_q <= tab_val;
      w_q   <= weights_all[cmd_i.step_k * WEIGHT_W +: WEIGHT_W];
    end
    prod_q <= PROD_W'(tab_q) * PROD_W'($signed({1'b0, w_q}));
    if (cmd_i.start) acc_q <= '0;
    else if (v2_q)   acc_q <= acc_q + ACC_W'(prod_q);
  end

  // gain scaling on the magnitude, truncating toward zero
  logic [ACC_W-1:0]          mag;
  logic [ACC_W+GAIN_W-1:0]   scaled_full;
  logic [SCALED_W-1:0]       scaled_q;
  logic                      neg_q;

  assign mag         = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign scaled_full = (ACC_W+GAIN_W)'(mag) * (ACC_W+GAIN_W)'(gain_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      scaled_q <= scaled_full[ACC_W+GAIN_W-1:32];
      neg_q    <= acc_q[ACC_W-1];
    end
  end

  // saturate to SAMPLE_BITS
  localparam logic [SCALED_W-1:0] LIM_POS = SCALED_W'((64'd1 << (SAMPLE_BITS-1)) - 64'd1);
  localparam logic [SCALED_W-1:0] LIM_NEG = SCALED_W'(64'd1 << (SAMPLE_BITS-1));
  logic signed [SAMPLE_BITS-1:0] sat;

  always_comb begin
    if (neg_q) begin
      if (scaled_q > LIM_NEG) sat = $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});
      else sat = -$signed(SAMPLE_BITS'(scaled_q));
    end else begin
      if (scaled_q > LIM_POS) sat = $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
      else sat = $signed(SAMPLE_BITS'(scaled_q));
    end
  end

  // output register
  logic               out_valid_q;
  logic [OUT_W-1:0]   out_sample_q;
  logic               out_last_q;

  // count, pipe busy, output blocked
  assign status_o = {count_eff, v1_q | v2_q, out_valid_q & ~out_ready_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_sample_q <= OUT_W'(sat);
      out_last_q   <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_last_o   = out_last_q;

endmodule

/* src/harmonic_tone_generator_core.sv */
// One word at a time: the input side takes a new word only after the last
// result is loaded. The single shared sine lookup and multiply-accumulate
// handle one harmonic per cycle.
// The result register frees the input side while a sample waits downstream.
// Reset (rst_ni low, asynchronous): phase, position and handshake state clear,
// and configuration returns to its defaults.
module harmonic_tone_generator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic [htg_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [htg_pkg::CFG_DW-1:0] cfg_wdata_i,
  // input words
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [0] restart, [7:1] zero
  // output words
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // [15:0] sample
  output logic                       m_axis_tlast   // loop_end
);
  import htg_pkg::*;

  htg_cmd_t    cmd;
  htg_status_t status;

  // Sequence each word: start, one step per harmonic, drain, scale, load.
  htg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold config and state; run the shared multiply-accumulate.
  htg_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .restart_i    (s_axis_tdata[0]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_sample_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

/* src/htg_checker.sv */
// Port-level checker for the harmonic tone generator, bound to the top level.
`include "harmonic_tone_generator_core_macros.svh"

module htg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic [16:0] out_word;

  assign out_word = {m_axis_tlast, m_axis_tdata};

  // a stalled output word holds
  `HTG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(out_word))

  // one word at a time: ready drops right after an accept
  `HTG_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a new result only appears after the block was busy
  `HTG_ASSERT_SAME(a_result_from_work, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind harmonic_tone_generator_core htg_checker u_htg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* test/tb.sv */
// Self-checking bench for the harmonic tone generator core: stream stimulus, model, scoreboard.
module tb;
  import htg_pkg::CFG_IW;
  import htg_pkg::CFG_DW;
  import htg_pkg::REG_PHASE_STEP;
  import htg_pkg::REG_HARMONIC_COUNT;
  import htg_pkg::REG_WEIGHTS_LOW;
  import htg_pkg::REG_WEIGHTS_HIGH;
  import htg_pkg::REG_NORM_GAIN;
  import htg_pkg::REG_LOOP_LENGTH;

  localparam int TONE_TAB_BITS = 10;
  localparam int TONE_QUARTER  = 1 << (TONE_TAB_BITS - 2);
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam longint unsigned PEAK        = 64'd32767;
  // Taylor divisors, innermost term first, one byte each
  localparam logic [47:0] TAYLOR_DIVS = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

  localparam int RANDOM_WORDS = 525;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 20;

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  // indexes with no register behind them; writes there must change nothing
  localparam logic [CFG_IW-1:0] REG_SPARE_A = CFG_IW'(6);
  localparam logic [CFG_IW-1:0] REG_SPARE_B = CFG_IW'(7);

  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_e;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               loop_end;
  } tone_word_t;

  typedef struct packed {
    row_kind_e          kind;
    logic [CFG_IW-1:0]  index;
    logic [CFG_DW-1:0]  data;
    logic               restart;
    logic               typed;
    logic signed [15:0] want_sample;
    logic               want_last;
  } tone_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_IW-1:0] cfg_index_i   = '0;
  logic [CFG_DW-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;  // [0] restart, [7:1] zero
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;        // [15:0] sample
  logic              m_axis_tlast;        // loop_end

  harmonic_tone_generator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Tone model: register copies and running state
  logic [31:0] tone_step;
  logic [3:0]  tone_harmonics;
  logic [63:0] tone_wlow;
  logic [63:0] tone_whigh;
  logic [19:0] tone_gain;
  logic [15:0] tone_loop_len;
  logic [31:0] tone_phase;
  logic [15:0] tone_pos;
  logic [15:0] quarter_wave [0:TONE_QUARTER];

  tone_word_t  pending_words [$];
  tone_row_t   script [$];

  bit          steady;
  int unsigned mismatches;
  int unsigned words_in;
  int unsigned words_out;
  int unsigned loop_ends;
  int unsigned restarts;
  int unsigned reg_writes;
  int unsigned stall_cycles;
  tone_word_t  oldest;

  // Quarter-wave sine in Q2.30 by nested Taylor terms, rounded to full scale
  function automatic void build_quarter_wave();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    for (int n = 0; n <= TONE_QUARTER; n++) begin
      x  = (Q30_HALF_PI * n) / TONE_QUARTER;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int i = 0; i < 6; i++) begin
        t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIVS[i*8 +: 8];
      end
      s = (x * t) >> 30;
      if (s > Q30_ONE) s = Q30_ONE;
      quarter_wave[n] = 16'((s * PEAK + (Q30_ONE >> 1)) >> 30);
    end
  endfunction

  // Full-wave lookup from the top table bits of the phase, mirrored per quadrant
  function automatic longint tone_sine(input logic [31:0] ph);
    logic [TONE_TAB_BITS-1:0] idx;
    longint                   v;
    idx = ph[31 -: TONE_TAB_BITS];
    if (idx[TONE_TAB_BITS-2]) v = quarter_wave[TONE_QUARTER - idx[TONE_TAB_BITS-3:0]];
    else v = quarter_wave[idx[TONE_TAB_BITS-3:0]];
    return idx[TONE_TAB_BITS-1] ? -v : v;
  endfunction

  // One sample: weighted harmonic sum, gain, saturate, then advance the loop
  function automatic tone_word_t predict_tone(input logic restart);
    int unsigned     harmonics;
    longint          acc;
    longint unsigned mag;
    longint unsigned scaled;
    logic [127:0]    weights;
    logic [31:0]     ph;
    tone_word_t      res;
    if (restart) begin
      tone_phase = '0;
      tone_pos   = '0;
    end
    harmonics = tone_harmonics;
    if (harmonics < 1) harmonics = 1;
    if (harmonics > 8) harmonics = 8;
    weights = {tone_whigh, tone_wlow};
    acc = 0;
    for (int k = 0; k < harmonics; k++) begin
      ph  = tone_phase * 32'(k + 1);
      acc += longint'({48'd0, weights[k*16 +: 16]}) * tone_sine(ph);
    end
    mag    = (acc < 0) ? -acc : acc;
    scaled = (mag * tone_gain) >> 32;
    if (acc < 0) res.sample = (scaled >= 64'd32768) ? 16'sh8000 : 16'(-scaled);
    else res.sample = (scaled > 64'd32767) ? 16'sh7FFF : 16'(scaled);
    // a zero length behaves as one; a position past the end closes the loop too
    res.loop_end = (32'(tone_pos) + 32'd1) >=
                   ((tone_loop_len == 16'd0) ? 32'd1 : 32'(tone_loop_len));
    if (res.loop_end) begin
      tone_pos   = '0;
      tone_phase = '0;
    end else begin
      tone_pos   = tone_pos + 16'd1;
      tone_phase = tone_phase + tone_step;
    end
    return res;
  endfunction

  function automatic tone_row_t set_reg(input logic [CFG_IW-1:0] idx,
                                        input logic [CFG_DW-1:0] val);
    return '{ROW_WRITE, idx, val, 1'b0, PREDICTED, 16'sd0, 1'b0};
  endfunction

  function automatic tone_row_t in_word(input logic restart, input logic typed,
                                        input logic signed [15:0] sample, input logic last);
    return '{ROW_WORD, REG_PHASE_STEP, 64'd0, restart, typed, sample, last};
  endfunction

  // Write one register while the block is idle, and mirror it into the model
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_PHASE_STEP:     tone_step      = val[31:0];
      REG_HARMONIC_COUNT: tone_harmonics = val[3:0];
      REG_WEIGHTS_LOW:    tone_wlow      = val;
      REG_WEIGHTS_HIGH:   tone_whigh     = val;
      REG_NORM_GAIN:      tone_gain      = val[19:0];
      REG_LOOP_LENGTH:    tone_loop_len  = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
  endtask

  // Drop valid, then hold until every pending sample has come out
  task automatic drain_words();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Offer one input word, with an occasional gap first; queue its expected sample
  task automatic send_word(input logic restart, input logic typed, input tone_word_t want);
    tone_word_t model_out;
    if (!steady && $urandom_range(0, 99) < 10) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    model_out = predict_tone(restart);
    pending_words.push_back(typed ? want : model_out);
    words_in++;
    if (restart) restarts++;
  endtask

  // Downstream stalls about one cycle in ten, except during the steady stretch
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
  end

  // Scoreboard: each output word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (m_axis_tlast) loop_ends++;
      if (pending_words.size() == 0) begin
        $error("unexpected output word: sample %0d, loop_end %0b",
               $signed(m_axis_tdata), m_axis_tlast);
        mismatches++;
      end else begin
        oldest = pending_words.pop_front();
        if (m_axis_tdata !== oldest.sample) begin
          $error("sample: expected %0d, got %0d", oldest.sample, $signed(m_axis_tdata));
          mismatches++;
        end
        if (m_axis_tlast !== oldest.loop_end) begin
          $error("loop_end: expected %0b, got %0b", oldest.loop_end, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: give up when no word moves and no register is written for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    tone_row_t     row;
    int unsigned   pick;
    int unsigned   burst;
    int unsigned   harmonics;
    int unsigned   phase_no;
    int unsigned   random_words;
    logic [15:0]   len;
    logic [3:0]    count;
    logic [31:0]   step;
    logic [63:0]   wlo;
    logic [63:0]   whi;
    logic [63:0]   junk;
    logic [127:0]  wall;
    longint unsigned weight_sum;
    longint unsigned recip;
    logic [19:0]   gain;

    build_quarter_wave();
    tone_step      = '0;
    tone_harmonics = 4'd1;
    tone_wlow      = '0;
    tone_whigh     = '0;
    tone_gain      = 20'h1_0000;
    tone_loop_len  = 16'd13200;
    tone_phase     = '0;
    tone_pos       = '0;
    steady         = 1'b0;
    phase_no       = 0;
    random_words   = 0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Defaults first: zero weights give silence.
    script.push_back(in_word(1'b0, TYPED, 16'sd0, 1'b0));
    script.push_back(in_word(1'b1, TYPED, 16'sd0, 1'b0));
    // zero loop length: every sample closes the loop
    script.push_back(set_reg(REG_LOOP_LENGTH, 64'd0));
    script.push_back(in_word(1'b0, TYPED, 16'sd0, 1'b1));
    // quarter-turn step, full weight, full gain: 0, +max, 0, -max, wrap to 0
    script.push_back(set_reg(REG_LOOP_LENGTH, 64'hFFFF));
    script.push_back(set_reg(REG_HARMONIC_COUNT, 64'd1));
    script.push_back(set_reg(REG_WEIGHTS_LOW, 64'hFFFF));
    script.push_back(set_reg(REG_NORM_GAIN, 64'hF_FFFF));
    script.push_back(set_reg(REG_PHASE_STEP, 64'h4000_0000));
    script.push_back(in_word(1'b1, TYPED, 16'sd0, 1'b0));
    script.push_back(in_word(1'b0, TYPED, 16'sh7FFF, 1'b0));
    script.push_back(in_word(1'b0, TYPED, 16'sd0, 1'b0));
    script.push_back(in_word(1'b0, TYPED, 16'sh8000, 1'b0));
    script.push_back(in_word(1'b0, TYPED, 16'sd0, 1'b0));
    // harmonic count zero acts as one; all weights at full scale
    script.push_back(set_reg(REG_HARMONIC_COUNT, 64'd0));
    script.push_back(set_reg(REG_WEIGHTS_LOW, '1));
    script.push_back(set_reg(REG_WEIGHTS_HIGH, '1));
    script.push_back(set_reg(REG_PHASE_STEP, 64'h0123_4567));
    script.push_back(in_word(1'b1, PREDICTED, 16'sd0, 1'b0));
    script.push_back(in_word(1'b0, PREDICTED, 16'sd0, 1'b0));
    // count above the maximum acts as eight
    script.push_back(set_reg(REG_HARMONIC_COUNT, 64'd15));
    script.push_back(in_word(1'b0, PREDICTED, 16'sd0, 1'b0));
    script.push_back(in_word(1'b0, PREDICTED, 16'sd0, 1'b0));
    script.push_back(in_word(1'b0, PREDICTED, 16'sd0, 1'b0));
    // zero gain silences everything
    script.push_back(set_reg(REG_HARMONIC_COUNT, 64'd8));
    script.push_back(set_reg(REG_NORM_GAIN, 64'd0));
    script.push_back(in_word(1'b0, TYPED, 16'sd0, 1'b0));
    script.push_back(set_reg(REG_NORM_GAIN, 64'd1));
    script.push_back(in_word(1'b0, PREDICTED, 16'sd0, 1'b0));
    // writes to unused indexes are dropped
    script.push_back(set_reg(REG_SPARE_A, '1));
    script.push_back(set_reg(REG_SPARE_B, '1));
    script.push_back(in_word(1'b0, PREDICTED, 16'sd0, 1'b0));
    // shorten the loop under a running position: the next sample closes it
    script.push_back(set_reg(REG_NORM_GAIN, 64'h1_0000));
    script.push_back(set_reg(REG_LOOP_LENGTH, 64'd20));
    script.push_back(set_reg(REG_WEIGHTS_LOW, 64'h1000_2000_4000_8000));
    script.push_back(set_reg(REG_WEIGHTS_HIGH, 64'h0100_0200_0400_0800));
    script.push_back(in_word(1'b1, PREDICTED, 16'sd0, 1'b0));
    repeat (5) script.push_back(in_word(1'b0, PREDICTED, 16'sd0, 1'b0));
    script.push_back(set_reg(REG_LOOP_LENGTH, 64'd3));
    script.push_back(in_word(1'b0, PREDICTED, 16'sd0, 1'b0));
    script.push_back(in_word(1'b0, PREDICTED, 16'sd0, 1'b0));

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_WRITE) begin
        drain_words();
        write_reg(row.index, row.data);
      end else begin
        send_word(row.restart, row.typed, '{row.want_sample, row.want_last});
      end
    end

    // Random part: a fresh setting per burst, bursts of mostly plain samples
    while (random_words < RANDOM_WORDS) begin
      steady = (phase_no >= 6 && phase_no < 9);
      drain_words();

      pick = $urandom_range(0, 7);
      if (pick == 0) len = 16'd0;
      else if (pick == 1) len = 16'hFFFF;
      else if (pick == 2) len = 16'($urandom);
      else len = 16'($urandom_range(1, 48));

      count = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 8));
      wlo = {$urandom, $urandom};
      whi = {$urandom, $urandom};
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
        wlo = '1;
        whi = '1;
      end else if (pick == 1) begin
        wlo = '0;
        whi = '0;
      end

      pick = $urandom_range(0, 7);
      if (pick == 0) step = '0;
      else if (pick == 1) step = '1;
      else if (pick < 4) step = $urandom;
      else step = 32'(((64'd1 << 32) * $urandom_range(1, 5)) / ((len == 0) ? 16'd1 : len));

      // software-style gain: reciprocal of the weight sum of the harmonics in use
      harmonics = (count == 0) ? 1 : (count > 8) ? 8 : count;
      wall = {whi, wlo};
      weight_sum = 0;
      for (int k = 0; k < harmonics; k++) weight_sum += wall[k*16 +: 16];
      recip = (weight_sum == 0) ? 64'hF_FFFF : (64'd1 << 32) / weight_sum;
      pick = $urandom_range(0, 7);
      if (pick == 0) gain = '0;
      else if (pick == 1) gain = '1;
      else if (pick == 2) gain = 20'($urandom);
      else gain = (recip > 64'hF_FFFF) ? 20'hF_FFFF : 20'(recip);

      // narrow registers sometimes get junk above their width
      junk = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : '0;
      write_reg(REG_LOOP_LENGTH, {junk[63:16], len});
      write_reg(REG_HARMONIC_COUNT, {junk[63:4], count});
      write_reg(REG_WEIGHTS_LOW, wlo);
      write_reg(REG_WEIGHTS_HIGH, whi);
      write_reg(REG_PHASE_STEP, {junk[63:32], step});
      write_reg(REG_NORM_GAIN, {junk[63:20], gain});
      if ($urandom_range(0, 3) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                  {$urandom, $urandom});
      end

      burst = $urandom_range(12, 50);
      if (burst > RANDOM_WORDS - random_words) burst = RANDOM_WORDS - random_words;
      for (int i = 0; i < burst; i++) begin
        if (i == 0) send_word(1'($urandom_range(0, 1)), PREDICTED, '0);
        else send_word($urandom_range(0, 99) < 4, PREDICTED, '0);
        random_words++;
      end
      phase_no++;
    end

    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d samples from %0d input words (%0d restarts), %0d loop ends.",
             words_out, words_in, restarts, loop_ends);
    $display("Register writes: %0d, over %0d random settings after the directed rows.",
             reg_writes, phase_no);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
